@@ hw/rtl/packet_admission_checker_macros.svh @@
// ----------------------------------------------------------------------------
// packet admission checker assertion macros
// concurrent checks sampled on the rising clock edge, off during reset
// ----------------------------------------------------------------------------
`ifndef PACKET_ADMISSION_CHECKER_MACROS_SVH
`define PACKET_ADMISSION_CHECKER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PAC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("packet admission checker: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("packet admission checker: next-cycle check failed");

`endif

@@ hw/rtl/pac_pkg.sv @@
// ----------------------------------------------------------------------------
// pac_pkg
// shared types, codes and constants of the packet admission checker
// ----------------------------------------------------------------------------
`default_nettype none

package pac_pkg;

    // fixed field widths
    localparam int DEV_IDX_W    = 8;
    localparam int DEV_IDX_SPAN = 1 << DEV_IDX_W;
    localparam int SEQ_W        = 32;
    localparam int KIND_W       = 3;
    localparam int VALUE_W      = 24;
    localparam int COUNT_W      = 8;
    localparam int VERDICT_W    = 3;
    localparam int THREAT_W     = 2;
    localparam int M_DATA_W     = 8;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 24;

    // register widths
    localparam int RATE_LIMIT_W    = 8;
    localparam int RATE_WINDOW_W   = 16;
    localparam int REPLAY_WINDOW_W = 24;
    localparam int TEMP_W          = 24;
    localparam int PERCENT_W       = 23;

    // register reset values
    localparam logic [RATE_LIMIT_W-1:0]    RATE_LIMIT_RST    = 8'd10;
    localparam logic [RATE_WINDOW_W-1:0]   RATE_WINDOW_RST   = 16'd1000;
    localparam logic [REPLAY_WINDOW_W-1:0] REPLAY_WINDOW_RST = 24'd30000;
    localparam logic signed [TEMP_W-1:0]   TEMP_MIN_RST      = -24'sd2560;
    localparam logic signed [TEMP_W-1:0]   TEMP_MAX_RST      = 24'sd15360;
    localparam logic [PERCENT_W-1:0]       PERCENT_MAX_RST   = 23'd25600;

    // valve on level, 1.0 in q15.8
    localparam logic signed [VALUE_W-1:0] VALVE_ON = 24'sd256;
    // rate counter ceiling
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RATE_LIMIT    = 3'd0,
        CFG_RATE_WINDOW   = 3'd1,
        CFG_REPLAY_WINDOW = 3'd2,
        CFG_TEMP_MIN      = 3'd3,
        CFG_TEMP_MAX      = 3'd4,
        CFG_PERCENT_MAX   = 3'd5
    } cfg_index_t;

    // sensor kinds with a range rule
    typedef enum logic [KIND_W-1:0] {
        KIND_SOIL     = 3'd0,
        KIND_TEMP     = 3'd1,
        KIND_HUMIDITY = 3'd2,
        KIND_VALVE    = 3'd3
    } sensor_kind_t;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_OK           = 3'd0,
        VERDICT_AUTH_FAIL    = 3'd1,
        VERDICT_RATE_LIMITED = 3'd2,
        VERDICT_OUT_OF_RANGE = 3'd3,
        VERDICT_REPLAY       = 3'd4
    } verdict_t;

    typedef enum logic [THREAT_W-1:0] {
        THREAT_NONE   = 2'd0,
        THREAT_MEDIUM = 2'd1,
        THREAT_HIGH   = 2'd2
    } threat_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic clear_wr;
        logic commit;
    } pac_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } pac_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/pac_ram.sv @@
// ----------------------------------------------------------------------------
// pac_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pac_ctrl.sv @@
// ----------------------------------------------------------------------------
// pac_ctrl
// sequencer: table clearing after reset, packet accept, evaluate and commit
// ----------------------------------------------------------------------------
`default_nettype none

module pac_ctrl
    import pac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire pac_status_t status,
    output logic             s_tready,
    output pac_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    state_next = ST_EVAL;
                    ready_next = 1'b0;
                end
            end
            ST_EVAL:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                ready_next = 1'b0;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    // commands
    always_comb
    begin
        cmd.accept   = s_tvalid && ready_reg;
        cmd.clear_wr = (state_reg == ST_CLEAR);
        cmd.commit   = (state_reg == ST_EVAL) && status.out_free;
    end

    assign s_tready = ready_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pac_datapath.sv @@
// ----------------------------------------------------------------------------
// pac_datapath
// config registers, per-device table, check logic and result register
// ----------------------------------------------------------------------------
`default_nettype none

module pac_datapath
    import pac_pkg::*;
#(
    parameter int DEVICE_COUNT = 256,
    parameter int TIME_BITS    = 48
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire pac_cmd_t                     cmd,
    output pac_status_t                       status,
    // packet fields
    input  wire logic [DEV_IDX_W-1:0]         device_index,
    input  wire logic [TIME_BITS-1:0]         time_now_ms,
    input  wire logic [TIME_BITS-1:0]         packet_time_ms,
    input  wire logic [SEQ_W-1:0]             seq_num,
    input  wire logic [KIND_W-1:0]            sensor_kind,
    input  wire logic signed [VALUE_W-1:0]    sample_value,
    input  wire logic                         mac_valid,
    // configuration writes
    input  wire logic                         cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_wdata,
    // result
    input  wire logic                         m_tready,
    output logic                              m_tvalid,
    output logic [M_DATA_W-1:0]               m_tdata
);

    localparam int IDX_W   = $clog2(DEVICE_COUNT);
    // table entry layout, lowest bits first: start, count, last sequence, seen
    localparam int CNT_LSB  = TIME_BITS;
    localparam int SEQ_LSB  = CNT_LSB + COUNT_W;
    localparam int SEEN_BIT = SEQ_LSB + SEQ_W;
    localparam int ENTRY_W  = SEEN_BIT + 1;
    localparam int PAD_W    = M_DATA_W - VERDICT_W - THREAT_W;

    // configuration registers
    logic [RATE_LIMIT_W-1:0]    rate_limit_reg;
    logic [RATE_WINDOW_W-1:0]   rate_window_reg;
    logic [REPLAY_WINDOW_W-1:0] replay_window_reg;
    logic signed [TEMP_W-1:0]   temp_min_reg;
    logic signed [TEMP_W-1:0]   temp_max_reg;
    logic [PERCENT_W-1:0]       percent_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_limit_reg    <= RATE_LIMIT_RST;
            rate_window_reg   <= RATE_WINDOW_RST;
            replay_window_reg <= REPLAY_WINDOW_RST;
            temp_min_reg      <= TEMP_MIN_RST;
            temp_max_reg      <= TEMP_MAX_RST;
            percent_max_reg   <= PERCENT_MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_RATE_LIMIT:    rate_limit_reg    <= cfg_wdata[RATE_LIMIT_W-1:0];
                CFG_RATE_WINDOW:   rate_window_reg   <= cfg_wdata[RATE_WINDOW_W-1:0];
                CFG_REPLAY_WINDOW: replay_window_reg <= cfg_wdata[REPLAY_WINDOW_W-1:0];
                CFG_TEMP_MIN:      temp_min_reg      <= $signed(cfg_wdata[TEMP_W-1:0]);
                CFG_TEMP_MAX:      temp_max_reg      <= $signed(cfg_wdata[TEMP_W-1:0]);
                CFG_PERCENT_MAX:   percent_max_reg   <= cfg_wdata[PERCENT_W-1:0];
                default:           ;
            endcase
        end
    end

    // device index folded into the table depth, one entry per index code
    logic [IDX_W-1:0] mod_lut [DEV_IDX_SPAN];

    for (genvar g = 0; g < DEV_IDX_SPAN; g++)
    begin : g_mod_lut
        assign mod_lut[g] = IDX_W'(g % DEVICE_COUNT);
    end

    // clearing pass counter
    logic [IDX_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // captured packet word
    logic [IDX_W-1:0]            idx_reg;
    logic [TIME_BITS-1:0]        now_reg;
    logic [TIME_BITS-1:0]        pkt_time_reg;
    logic [SEQ_W-1:0]            seq_reg;
    logic [KIND_W-1:0]           kind_reg;
    logic signed [VALUE_W-1:0]   value_reg;
    logic                        mac_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg      <= mod_lut[device_index];
            now_reg      <= time_now_ms;
            pkt_time_reg <= packet_time_ms;
            seq_reg      <= seq_num;
            kind_reg     <= sensor_kind;
            value_reg    <= sample_value;
            mac_reg      <= mac_valid;
        end
    end

    // per-device table
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_data;
    logic [ENTRY_W-1:0] entry_next;

    assign ram_wr_en   = cmd.clear_wr || (cmd.commit && mac_reg);
    assign ram_wr_addr = cmd.clear_wr ? clr_cnt_reg : idx_reg;
    assign ram_wr_data = cmd.clear_wr ? '0 : entry_next;

    pac_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEVICE_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (mod_lut[device_index]),
        .rd_data (ram_rd_data)
    );

    // entry fields
    logic [TIME_BITS-1:0] win_start;
    logic [COUNT_W-1:0]   win_count;
    logic [SEQ_W-1:0]     last_seq;
    logic                 seen;

    assign win_start = ram_rd_data[TIME_BITS-1:0];
    assign win_count = ram_rd_data[CNT_LSB +: COUNT_W];
    assign last_seq  = ram_rd_data[SEQ_LSB +: SEQ_W];
    assign seen      = ram_rd_data[SEEN_BIT];

    // rate window
    logic [TIME_BITS-1:0] elapsed;
    logic                 restart;
    logic [COUNT_W-1:0]   count_base;
    logic [COUNT_W-1:0]   count_new;
    logic                 limited;

    always_comb
    begin
        elapsed    = now_reg - win_start;
        restart    = elapsed >= TIME_BITS'(rate_window_reg);
        count_base = restart ? '0 : win_count;
        count_new  = (count_base != COUNT_MAX) ? count_base + 1'b1 : count_base;
        limited    = count_new > rate_limit_reg;
    end

    // replay check, plain distance with no wrap handling
    logic [TIME_BITS-1:0] stamp_gap;
    logic                 replay;

    always_comb
    begin
        stamp_gap = (now_reg >= pkt_time_reg) ? now_reg - pkt_time_reg
                                              : pkt_time_reg - now_reg;
        replay    = seen && ((stamp_gap > TIME_BITS'(replay_window_reg))
                             || (seq_reg <= last_seq));
    end

    // range check by sensor kind
    logic range_ok;

    always_comb
    begin
        unique case (kind_reg)
            KIND_SOIL, KIND_HUMIDITY:
                range_ok = (value_reg >= 0) && (value_reg <= $signed({1'b0, percent_max_reg}));
            KIND_TEMP:
                range_ok = (value_reg >= temp_min_reg) && (value_reg <= temp_max_reg);
            KIND_VALVE:
                range_ok = (value_reg == 0) || (value_reg == VALVE_ON);
            default:
                range_ok = 1'b1;
        endcase
    end

    // verdict and write-back entry
    verdict_t verdict;
    threat_t  threat;
    logic     pass_seq;

    always_comb
    begin
        pass_seq = !limited && !replay;
        priority if (!mac_reg)
        begin
            verdict = VERDICT_AUTH_FAIL;
            threat  = THREAT_HIGH;
        end
        else if (limited)
        begin
            verdict = VERDICT_RATE_LIMITED;
            threat  = THREAT_HIGH;
        end
        else if (replay)
        begin
            verdict = VERDICT_REPLAY;
            threat  = THREAT_HIGH;
        end
        else if (!range_ok)
        begin
            verdict = VERDICT_OUT_OF_RANGE;
            threat  = THREAT_MEDIUM;
        end
        else
        begin
            verdict = VERDICT_OK;
            threat  = THREAT_NONE;
        end
        entry_next = {pass_seq | seen,
                      pass_seq ? seq_reg : last_seq,
                      count_new,
                      restart ? now_reg : win_start};
    end

    // result register
    logic                 out_valid_reg;
    logic [VERDICT_W-1:0] verdict_reg;
    logic [THREAT_W-1:0]  threat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            verdict_reg <= verdict;
            threat_reg  <= threat;
        end
    end

    assign m_tvalid          = out_valid_reg;
    assign m_tdata           = {{PAD_W{1'b0}}, threat_reg, verdict_reg};
    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.clear_last = (clr_cnt_reg == IDX_W'(DEVICE_COUNT - 1));

endmodule

`default_nettype wire

@@ hw/rtl/packet_admission_checker.sv @@
// ----------------------------------------------------------------------------
// packet_admission_checker
// per-packet admission verdict: auth, fixed-window rate limit, replay, range
//
// input channel s_*: one packet header word per handshake, sensor kind on
// s_tuser. output channel m_*: one verdict word per packet, in order.
// configuration: cfg_wr_en writes cfg_wdata into register cfg_index at the
// clock edge; unknown indexes are dropped. write only while idle.
// sequence: an accepted packet is captured and its table entry read; the
// check, write-back and result register load follow once the output frees.
// a new packet is taken only after the last one commits, as set by the
// per-device table read-then-write. reset: config registers take defaults and
// the table is cleared in a pass over all DEVICE_COUNT entries, s_tready low.
// stall: a waiting verdict is held in the output register; one more packet
// is accepted and read, and its check waits until the output frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_admission_checker_macros.svh"

module packet_admission_checker
    import pac_pkg::*;
#(
    parameter int DEVICE_COUNT = 256,
    parameter int TIME_BITS    = 48
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // packet header words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // device_index, time_now_ms, packet_time_ms, seq_num,
    // sample_value, mac_valid
    input  wire logic [((2*TIME_BITS+65+7)/8)*8-1:0] s_tdata,
    // sensor_kind
    input  wire logic [KIND_W-1:0]                 s_tuser,
    // verdict words
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // verdict, threat
    output logic [M_DATA_W-1:0]                    m_tdata,
    // configuration writes
    input  wire logic                              cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0]             cfg_wdata
);

    // field offsets in s_tdata
    localparam int OFF_NOW = DEV_IDX_W;
    localparam int OFF_PKT = OFF_NOW + TIME_BITS;
    localparam int OFF_SEQ = OFF_PKT + TIME_BITS;
    localparam int OFF_VAL = OFF_SEQ + SEQ_W;
    localparam int OFF_MAC = OFF_VAL + VALUE_W;

    pac_cmd_t    cmd;
    pac_status_t status;

    pac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    pac_datapath #(
        .DEVICE_COUNT (DEVICE_COUNT),
        .TIME_BITS    (TIME_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .device_index    (s_tdata[DEV_IDX_W-1:0]),
        .time_now_ms     (s_tdata[OFF_NOW +: TIME_BITS]),
        .packet_time_ms  (s_tdata[OFF_PKT +: TIME_BITS]),
        .seq_num         (s_tdata[OFF_SEQ +: SEQ_W]),
        .sensor_kind     (s_tuser),
        .sample_value    ($signed(s_tdata[OFF_VAL +: VALUE_W])),
        .mac_valid       (s_tdata[OFF_MAC]),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .m_tdata         (m_tdata)
    );

    // one packet in flight: ready drops right after an accept
    `PAC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // a commit always leaves a verdict on the output
    `PAC_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, m_tvalid)
    // no packet is taken while the table is being cleared
    `PAC_ASSERT_SAME(a_clear_blocks, clk, rst_n, cmd.clear_wr, !s_tready && !cmd.commit)

endmodule

`default_nettype wire

@@ tb/tb_packet_admission_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_admission_checker
// drives packet header words into the admission checker and compares every
// verdict word against an in-bench model of the auth, rate window, replay and
// range checks; runs directed corner packets, then randomized phases under
// several register settings and handshake idle patterns
// ----------------------------------------------------------------------------

module tb_packet_admission_checker;
    import pac_pkg::*;

    localparam int TIME_W   = 48;
    localparam int S_DATA_W = ((2*TIME_W+65+7)/8)*8;
    localparam int S_PAD_W  = S_DATA_W - (DEV_IDX_W + 2*TIME_W + SEQ_W + VALUE_W + 1);
    localparam int PAD_LO   = VERDICT_W + THREAT_W;

    // register indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    // base time of the directed packets
    localparam logic [TIME_W-1:0] T0 = 48'h0000_0100_0000;

    typedef struct {
        logic [DEV_IDX_W-1:0]      device;
        logic [TIME_W-1:0]         now_ms;
        logic [TIME_W-1:0]         stamp_ms;
        logic [SEQ_W-1:0]          seq;
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic                      mac_ok;
    } packet_t;

    typedef struct {
        verdict_t verdict;
        threat_t  threat;
    } verdict_pair_t;

    // per-device window, sequence and seen tables plus the register copy
    class verdict_predictor;
        logic [TIME_W-1:0]          win_start [DEV_IDX_SPAN];
        logic [COUNT_W-1:0]         win_count [DEV_IDX_SPAN];
        logic [SEQ_W-1:0]           last_seq  [DEV_IDX_SPAN];
        bit                         seen      [DEV_IDX_SPAN];
        logic [RATE_LIMIT_W-1:0]    rate_limit;
        logic [RATE_WINDOW_W-1:0]   rate_window;
        logic [REPLAY_WINDOW_W-1:0] replay_window;
        logic signed [TEMP_W-1:0]   temp_min;
        logic signed [TEMP_W-1:0]   temp_max;
        logic [PERCENT_W-1:0]       percent_max;
        verdict_pair_t              pending_verdicts [$];
        int unsigned                errors;

        function new();
            foreach (win_start[i])
            begin
                win_start[i] = '0;
                win_count[i] = '0;
                last_seq[i]  = '0;
                seen[i]      = 1'b0;
            end
            rate_limit    = RATE_LIMIT_RST;
            rate_window   = RATE_WINDOW_RST;
            replay_window = REPLAY_WINDOW_RST;
            temp_min      = TEMP_MIN_RST;
            temp_max      = TEMP_MAX_RST;
            percent_max   = PERCENT_MAX_RST;
            errors        = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_RATE_LIMIT:    rate_limit    = data[RATE_LIMIT_W-1:0];
                CFG_RATE_WINDOW:   rate_window   = data[RATE_WINDOW_W-1:0];
                CFG_REPLAY_WINDOW: replay_window = data[REPLAY_WINDOW_W-1:0];
                CFG_TEMP_MIN:      temp_min      = data[TEMP_W-1:0];
                CFG_TEMP_MAX:      temp_max      = data[TEMP_W-1:0];
                CFG_PERCENT_MAX:   percent_max   = data[PERCENT_W-1:0];
                default:           ;
            endcase
        endfunction

        function bit value_in_range(logic [KIND_W-1:0] kind, logic signed [VALUE_W-1:0] v);
            case (kind)
                KIND_SOIL, KIND_HUMIDITY:
                    return v >= 0 && v <= $signed({1'b0, percent_max});
                KIND_TEMP:
                    return v >= temp_min && v <= temp_max;
                KIND_VALVE:
                    return v == 0 || v == VALVE_ON;
                default:
                    return 1'b1;
            endcase
        endfunction

        // works out the verdict of one accepted packet and updates the tables
        function void note_packet(packet_t p);
            verdict_pair_t     want;
            logic [TIME_W-1:0] elapsed;
            logic [TIME_W-1:0] gap;
            bit                replay;
            want.verdict = VERDICT_AUTH_FAIL;
            want.threat  = THREAT_HIGH;
            if (p.mac_ok)
            begin
                elapsed = p.now_ms - win_start[p.device];
                if (elapsed >= TIME_W'(rate_window))
                begin
                    win_start[p.device] = p.now_ms;
                    win_count[p.device] = '0;
                end
                if (win_count[p.device] != COUNT_MAX)
                    win_count[p.device] = win_count[p.device] + 8'd1;
                if (win_count[p.device] > rate_limit)
                    want.verdict = VERDICT_RATE_LIMITED;
                else
                begin
                    replay = 1'b0;
                    if (seen[p.device])
                    begin
                        gap = (p.now_ms >= p.stamp_ms) ? p.now_ms - p.stamp_ms
                                                       : p.stamp_ms - p.now_ms;
                        if (gap > TIME_W'(replay_window))
                            replay = 1'b1;
                        else if (p.seq <= last_seq[p.device])
                            replay = 1'b1;
                    end
                    if (replay)
                        want.verdict = VERDICT_REPLAY;
                    else
                    begin
                        last_seq[p.device] = p.seq;
                        seen[p.device]     = 1'b1;
                        if (value_in_range(p.kind, p.value))
                        begin
                            want.verdict = VERDICT_OK;
                            want.threat  = THREAT_NONE;
                        end
                        else
                        begin
                            want.verdict = VERDICT_OUT_OF_RANGE;
                            want.threat  = THREAT_MEDIUM;
                        end
                    end
                end
            end
            pending_verdicts.push_back(want);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t: verdict mismatch: %s", $time, msg);
        endfunction

        // compares one verdict word with the oldest expectation
        function void check_word(logic [M_DATA_W-1:0] word);
            verdict_pair_t want;
            if (pending_verdicts.size() == 0)
            begin
                flag($sformatf("word %h with no packet waiting", word));
                return;
            end
            want = pending_verdicts.pop_front();
            if (word[VERDICT_W-1:0] !== want.verdict)
                flag($sformatf("verdict expected %0d, got %0d",
                               want.verdict, word[VERDICT_W-1:0]));
            if (word[PAD_LO-1:VERDICT_W] !== want.threat)
                flag($sformatf("threat expected %0d, got %0d",
                               want.threat, word[PAD_LO-1:VERDICT_W]));
            if (word[M_DATA_W-1:PAD_LO] !== '0)
                flag($sformatf("padding expected 0, got %0d", word[M_DATA_W-1:PAD_LO]));
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic [KIND_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    verdict_predictor       verdicts;

    // packet generator state
    logic [TIME_W-1:0]      gen_now;
    logic [SEQ_W-1:0]       seq_next [DEV_IDX_SPAN];
    logic [DEV_IDX_W-1:0]   dev_base;
    int unsigned            dev_pool;
    int unsigned            step_max;
    int unsigned            jump_pct;

    // handshake pressure knobs
    int unsigned            tx_idle_pct  = 0;
    int unsigned            rx_stall_pct = 0;
    int unsigned            rx_hold_len  = 0;

    packet_admission_checker #(
        .DEVICE_COUNT (DEV_IDX_SPAN),
        .TIME_BITS    (TIME_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    function automatic packet_t make_packet(logic [DEV_IDX_W-1:0] device,
                                            logic [TIME_W-1:0] now_ms,
                                            logic [TIME_W-1:0] stamp_ms,
                                            logic [SEQ_W-1:0] seq,
                                            logic [KIND_W-1:0] kind,
                                            logic signed [VALUE_W-1:0] value,
                                            logic mac_ok);
        packet_t p;
        p.device   = device;
        p.now_ms   = now_ms;
        p.stamp_ms = stamp_ms;
        p.seq      = seq;
        p.kind     = kind;
        p.value    = value;
        p.mac_ok   = mac_ok;
        return p;
    endfunction

    // sensor value aimed at the bounds of the kind's range rule
    function automatic logic signed [VALUE_W-1:0] pick_value(logic [KIND_W-1:0] kind);
        longint lo;
        longint hi;
        case (kind)
            KIND_SOIL, KIND_HUMIDITY:
            begin
                lo = 0;
                hi = longint'(verdicts.percent_max);
            end
            KIND_TEMP:
            begin
                lo = longint'(verdicts.temp_min);
                hi = longint'(verdicts.temp_max);
            end
            KIND_VALVE:
            begin
                case ($urandom_range(0, 5))
                    0: return 24'sd0;
                    1: return VALVE_ON;
                    2: return VALVE_ON - 24'sd1;
                    3: return VALVE_ON + 24'sd1;
                    4: return -24'sd1;
                    default: return 24'($urandom);
                endcase
            end
            default:
                return 24'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: return 24'($urandom);
            1: return 24'(lo);
            2: return 24'(lo - 1);
            3: return 24'(hi);
            4: return 24'(hi + 1);
            default:
            begin
                if (hi < lo)
                    return 24'($urandom);
                return 24'(lo + longint'($urandom_range(0, 32'(hi - lo))));
            end
        endcase
    endfunction

    // mostly well-formed traffic from a small device pool, some raw noise
    function automatic packet_t next_packet();
        packet_t           p;
        logic [TIME_W-1:0] offset;
        int unsigned       reach;
        if ($urandom_range(1, 100) <= 8)
        begin
            p = make_packet(8'($urandom), rand_time(), rand_time(), $urandom,
                            3'($urandom), 24'($urandom), 1'($urandom));
            return p;
        end
        p.device = dev_base + 8'($urandom_range(0, dev_pool - 1));
        // time moves on, now and then past a whole rate window
        if ($urandom_range(1, 100) <= jump_pct)
            gen_now = gen_now + TIME_W'(verdicts.rate_window) + 48'($urandom_range(1, 50));
        else
            gen_now = gen_now + 48'($urandom_range(0, step_max));
        p.now_ms = gen_now;
        // stamp within the replay window, on its edge, or just outside
        reach = verdicts.replay_window;
        case ($urandom_range(0, 19))
            0, 1: offset = TIME_W'(reach) + 48'($urandom_range(1, 3));
            2:    offset = TIME_W'(reach);
            default: offset = 48'($urandom_range(0, reach));
        endcase
        p.stamp_ms = $urandom_range(0, 1) ? gen_now + offset : gen_now - offset;
        // sequence rises per device, with repeats and steps back
        if ($urandom_range(1, 100) <= 8)
            p.seq = seq_next[p.device] - 32'($urandom_range(0, 2));
        else
        begin
            seq_next[p.device] = seq_next[p.device] + 32'($urandom_range(1, 4));
            p.seq = seq_next[p.device];
        end
        p.mac_ok = ($urandom_range(1, 100) > 3);
        p.kind   = ($urandom_range(1, 100) <= 85) ? 3'($urandom_range(0, 3))
                                                  : 3'($urandom_range(4, 7));
        p.value  = pick_value(p.kind);
        return p;
    endfunction

    // offers one packet word, holding it until the handshake
    task automatic send_packet(input packet_t p);
        while ($urandom_range(1, 100) <= tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{S_PAD_W{1'b0}}, p.mac_ok, p.value, p.seq,
                     p.stamp_ms, p.now_ms, p.device};
        s_tuser  <= p.kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        verdicts.note_packet(p);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (verdicts.pending() != 0);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
        verdicts.write_register(index, data);
    endtask

    // corner packets under the reset register values
    task automatic send_directed();
        // auth failure, first sighting, equal and lower sequence numbers
        send_packet(make_packet(8'd0, T0, T0, 32'd5, KIND_SOIL, 24'sd0, 1'b0));
        send_packet(make_packet(8'd0, T0, T0, 32'd5, KIND_SOIL, 24'sd0, 1'b1));
        send_packet(make_packet(8'd0, T0 + 48'd1, T0 + 48'd1, 32'd5, KIND_SOIL, 24'sd0, 1'b1));
        send_packet(make_packet(8'd0, T0 + 48'd1, T0 + 48'd1, 32'd4, KIND_SOIL, 24'sd0, 1'b1));
        // stale stamp, then a stamp right on the replay window
        send_packet(make_packet(8'd0, T0 + 48'd2, T0 + 48'd2 - 48'd30001, 32'd6,
                                KIND_SOIL, 24'sd0, 1'b1));
        send_packet(make_packet(8'd0, T0 + 48'd3, T0 + 48'd3 + 48'd30000, 32'd6,
                                KIND_SOIL, 24'sd25600, 1'b1));
        // percent and temperature bounds
        send_packet(make_packet(8'd0, T0 + 48'd4, T0, 32'd7, KIND_SOIL, 24'sd25601, 1'b1));
        send_packet(make_packet(8'd0, T0 + 48'd5, T0, 32'd8, KIND_SOIL, -24'sd1, 1'b1));
        send_packet(make_packet(8'd0, T0 + 48'd6, T0, 32'd9, KIND_HUMIDITY, 24'sd25600, 1'b1));
        send_packet(make_packet(8'd0, T0 + 48'd7, T0, 32'd10, KIND_TEMP, -24'sd2560, 1'b1));
        send_packet(make_packet(8'd0, T0 + 48'd8, T0, 32'd11, KIND_TEMP, -24'sd2561, 1'b1));
        send_packet(make_packet(8'd0, T0 + 48'd9, T0, 32'd12, KIND_TEMP, 24'sd15361, 1'b1));
        // twelfth counted packet in the window is rate limited
        send_packet(make_packet(8'd0, T0 + 48'd10, T0, 32'd13, KIND_TEMP, 24'sd15360, 1'b1));
        // window restarts exactly one window length later
        send_packet(make_packet(8'd0, T0 + 48'd1000, T0, 32'd13, KIND_TEMP, 24'sd15360, 1'b1));
        // valve levels
        send_packet(make_packet(8'd1, T0, T0, 32'd1, KIND_VALVE, 24'sd0, 1'b1));
        send_packet(make_packet(8'd2, T0, T0, 32'd1, KIND_VALVE, VALVE_ON, 1'b1));
        send_packet(make_packet(8'd3, T0, T0, 32'd1, KIND_VALVE, 24'sd255, 1'b1));
        send_packet(make_packet(8'd4, T0, T0, 32'd1, KIND_VALVE, 24'sd257, 1'b1));
        // kinds without a rule, full-scale values and fields
        send_packet(make_packet(8'd5, T0, T0, 32'd1, 3'd7, 24'sh800000, 1'b1));
        send_packet(make_packet(8'd255, 48'hFFFF_FFFF_FFFF, 48'd0, 32'hFFFF_FFFF,
                                3'd4, 24'sh7FFFFF, 1'b1));
        // time wraps inside the rate window; stamp far off, top sequence
        send_packet(make_packet(8'd255, 48'd0, 48'd0, 32'd0, 3'd5, 24'sd0, 1'b1));
        send_packet(make_packet(8'd6, T0, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF,
                                3'd6, 24'sh555555, 1'b1));
        send_packet(make_packet(8'd6, T0, 48'hFFFF_FFFF_FFFF, 32'h8000_0000,
                                3'd6, 24'shAAAAAA, 1'b1));
    endtask

    // one register setting with its own traffic shape and idle pattern
    task automatic run_phase(input int phase);
        int          items;
        int          i;
        wait_drained();
        gen_now  = rand_time();
        jump_pct = 3;
        case (phase)
            0:
            begin
                write_register(CFG_RATE_LIMIT, 24'd4);
                write_register(CFG_RATE_WINDOW, 24'd200);
                write_register(CFG_REPLAY_WINDOW, 24'd1000);
                write_register(CFG_TEMP_MIN, TEMP_MIN_RST);
                write_register(CFG_TEMP_MAX, TEMP_MAX_RST);
                write_register(CFG_PERCENT_MAX, 24'(PERCENT_MAX_RST));
                dev_base = 8'd0;
                dev_pool = 6;
                step_max = 30;
                items    = 200;
            end
            1:
            begin
                // widest settings
                write_register(CFG_RATE_LIMIT, 24'd255);
                write_register(CFG_RATE_WINDOW, 24'd65535);
                write_register(CFG_REPLAY_WINDOW, 24'hFFFFFF);
                write_register(CFG_TEMP_MIN, 24'h800000);
                write_register(CFG_TEMP_MAX, 24'h7FFFFF);
                write_register(CFG_PERCENT_MAX, 24'h7FFFFF);
                dev_base = 8'd250;
                dev_pool = 6;
                step_max = 5000;
                items    = 200;
            end
            2:
            begin
                // narrowest settings, time wraps during the phase
                write_register(CFG_RATE_LIMIT, 24'd1);
                write_register(CFG_RATE_WINDOW, 24'd0);
                write_register(CFG_REPLAY_WINDOW, 24'd0);
                write_register(CFG_TEMP_MIN, 24'd0);
                write_register(CFG_TEMP_MAX, 24'd0);
                write_register(CFG_PERCENT_MAX, 24'd0);
                gen_now  = 48'hFFFF_FFFF_FF00;
                dev_base = 8'd100;
                dev_pool = 6;
                step_max = 3;
                items    = 200;
            end
            3:
            begin
                // zero rate limit, inverted temperature range, spare indexes
                write_register(CFG_RATE_LIMIT, 24'd0);
                write_register(CFG_RATE_WINDOW, 24'd1);
                write_register(CFG_REPLAY_WINDOW, 24'd1);
                write_register(CFG_TEMP_MIN, 24'd100);
                write_register(CFG_TEMP_MAX, 24'hFFFF9C);
                write_register(CFG_PERCENT_MAX, 24'd1);
                write_register(CFG_SPARE_LO, 24'hFFFFFF);
                write_register(CFG_SPARE_HI, 24'h123456);
                dev_base = 8'd40;
                dev_pool = 6;
                step_max = 2;
                items    = 100;
            end
            4:
            begin
                // one device hammered inside one long window: count saturates
                write_register(CFG_RATE_LIMIT, 24'd200);
                write_register(CFG_RATE_WINDOW, 24'd65535);
                write_register(CFG_REPLAY_WINDOW, 24'd5000);
                write_register(CFG_TEMP_MIN, 24'hFFEC00);
                write_register(CFG_TEMP_MAX, 24'd10240);
                write_register(CFG_PERCENT_MAX, 24'd12800);
                dev_base = 8'd7;
                dev_pool = 1;
                step_max = 2;
                jump_pct = 0;
                items    = 340;
            end
            5:
            begin
                write_register(CFG_RATE_LIMIT, 24'($urandom_range(1, 20)));
                write_register(CFG_RATE_WINDOW, 24'($urandom_range(1, 3000)));
                write_register(CFG_REPLAY_WINDOW, 24'($urandom_range(0, 50000)));
                write_register(CFG_TEMP_MIN, 24'(32'd0 - $urandom_range(0, 20000)));
                write_register(CFG_TEMP_MAX, 24'($urandom_range(0, 40000)));
                write_register(CFG_PERCENT_MAX, 24'($urandom_range(0, 60000)));
                dev_base = 8'($urandom);
                dev_pool = 16;
                step_max = verdicts.rate_window / 8 + 1;
                items    = 220;
            end
            default:
            begin
                // back to the reset values
                write_register(CFG_RATE_LIMIT, 24'(RATE_LIMIT_RST));
                write_register(CFG_RATE_WINDOW, 24'(RATE_WINDOW_RST));
                write_register(CFG_REPLAY_WINDOW, REPLAY_WINDOW_RST);
                write_register(CFG_TEMP_MIN, TEMP_MIN_RST);
                write_register(CFG_TEMP_MAX, TEMP_MAX_RST);
                write_register(CFG_PERCENT_MAX, 24'(PERCENT_MAX_RST));
                dev_base = 8'd0;
                dev_pool = 8;
                step_max = 100;
                items    = 180;
            end
        endcase
        cfg_wr_en <= 1'b0;
        // idle pattern rotates with the phase
        case (phase % 4)
            0:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            1:
            begin
                tx_idle_pct  = 54;
                rx_stall_pct = 0;
            end
            2:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 54;
            end
            default:
            begin
                tx_idle_pct  = 27;
                rx_stall_pct = 27;
            end
        endcase
        for (i = 0; i < items; i++)
        begin
            // long receiver hold while packets keep coming
            if (phase == 4 && i == 120)
                rx_hold_len = 250;
            // sender pause until every verdict is back
            if (phase == 5 && i == 110)
                wait_drained();
            send_packet(next_packet());
        end
    endtask

    // verdict word monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid && m_tready)
            verdicts.check_word(m_tdata);
    end

    // receiver: random stalls, or a counted hold when one is requested
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_len != 0)
            begin
                hold_left   = rx_hold_len;
                rx_hold_len = 0;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(1, 100) > rx_stall_pct);
        end
    end

    initial
    begin : stimulus
        int p;
        verdicts = new();
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        foreach (seq_next[i])
            seq_next[i] = 32'($urandom_range(0, 32'h7FFF_FFFF));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_directed();
        for (p = 0; p < 7; p++)
            run_phase(p);
        wait_drained();
        repeat (10) @(posedge clk);
        if (verdicts.errors == 0 && verdicts.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
